// ===== sv/tfr_pkg.sv =====
// shared constants for the triangle fill rasterizer
package tfr_pkg;

	localparam int DISPLAY_COLUMNS = 120;
	localparam int DISPLAY_ROWS    = 48;
	localparam int STORE_DEPTH     = DISPLAY_COLUMNS * DISPLAY_ROWS;
	localparam int ADDR_W          = $clog2(STORE_DEPTH);

	localparam int COORD_W    = 8;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 3 * CHAN_W;
	localparam int COUNT_W    = 13;
	localparam int RD_COL_W   = 7;
	localparam int RD_ROW_W   = 6;
	localparam int OPND_W     = 10;
	localparam int EDGE_W     = 2 * OPND_W;

	localparam logic [COORD_W-1:0] COL_LAST = COORD_W'(DISPLAY_COLUMNS - 1);
	localparam logic [COORD_W-1:0] ROW_LAST = COORD_W'(DISPLAY_ROWS - 1);

	localparam logic KIND_DRAW = 1'b0;
	localparam logic KIND_READ = 1'b1;

endpackage

// ===== sv/tfr_cmd_if.sv =====
// command channel: draw or read request
interface tfr_cmd_if import tfr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [COORD_W-1:0]  ax;
	logic [COORD_W-1:0]  ay;
	logic [COORD_W-1:0]  bx;
	logic [COORD_W-1:0]  by;
	logic [COORD_W-1:0]  cx;
	logic [COORD_W-1:0]  cy;
	logic [CHAN_W-1:0]   fill_red;
	logic [CHAN_W-1:0]   fill_green;
	logic [CHAN_W-1:0]   fill_blue;
	logic [RD_COL_W-1:0] read_column;
	logic [RD_ROW_W-1:0] read_row;

	modport source (
		output valid, kind, ax, ay, bx, by, cx, cy,
		output fill_red, fill_green, fill_blue, read_column, read_row,
		input  ready
	);
	modport sink (
		input  valid, kind, ax, ay, bx, by, cx, cy,
		input  fill_red, fill_green, fill_blue, read_column, read_row,
		output ready
	);
endinterface

// ===== sv/tfr_rsp_if.sv =====
// response channel: read pixel or painted count
interface tfr_rsp_if import tfr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAN_W-1:0]  pixel_red;
	logic [CHAN_W-1:0]  pixel_green;
	logic [CHAN_W-1:0]  pixel_blue;
	logic [COUNT_W-1:0] painted_count;

	modport source (
		output valid, pixel_red, pixel_green, pixel_blue, painted_count,
		input  ready
	);
	modport sink (
		input  valid, pixel_red, pixel_green, pixel_blue, painted_count,
		output ready
	);
endinterface

// ===== sv/tfr_ram.sv =====
// generic single write port, single read port ram with registered read
module tfr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 5760
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/triangle_fill_rasterizer.sv =====
// triangle fill rasterizer: edge function scan into an rgb888 frame store
//
//  channel  dir  carries
//  cmd      in   kind, three vertices, fill color, read column and row
//  rsp      out  read pixel color bytes, painted pixel count
//
// a draw is accepted, runs its setup steps on the shared multiplier, then scans one
// pixel of the clipped bounding box per cycle (an empty box skips the scan), then loads
// the result. a read forms the row base on the multiplier, reads the store, loads the result.
// the frame store has no clearing pass; entries are undefined until drawn.
// the result sits in an output register, so the next command is taken while
// it waits; a finished command holds in its last state until that register frees.
module triangle_fill_rasterizer import tfr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	tfr_cmd_if.sink   cmd,
	tfr_rsp_if.source rsp
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SETUP  = 6'b000010,
		S_SCAN   = 6'b000100,
		S_RADDR  = 6'b001000,
		S_RREQ   = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;

	logic [2:0] step_q;

	logic [COORD_W-1:0] vx_q [3];
	logic [COORD_W-1:0] vy_q [3];
	logic [COORD_W-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic               empty_q;
	logic               is_read_q;
	logic               rd_ok_q;
	logic [RD_COL_W-1:0] rd_col_q;
	logic [RD_ROW_W-1:0] rd_row_q;
	logic [COLOR_W-1:0] color_q;

	logic signed [EDGE_W-1:0] e_q  [3];
	logic signed [EDGE_W-1:0] er_q [3];
	logic signed [EDGE_W-1:0] prod_q;
	logic [ADDR_W-1:0]        addr_q, row_addr_q;
	logic [COUNT_W-1:0]       count_q;

	logic               out_valid_q;
	logic [CHAN_W-1:0]  pixel_red_q, pixel_green_q, pixel_blue_q;
	logic [COUNT_W-1:0] painted_count_q;

	logic cmd_fire;
	logic out_free;
	logic rsp_load;
	logic [COORD_W-1:0] xmin, xmax, ymin, ymax, xlim, ylim;
	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic signed [EDGE_W-1:0] dx_ext [3];
	logic signed [EDGE_W-1:0] dy_ext [3];
	logic neg, pos, paint;
	logic last_col, last_pix;
	logic ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [COLOR_W-1:0] ram_rdata;

	localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(DISPLAY_COLUMNS);

	function automatic logic [COORD_W-1:0] min3(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] c);
		logic [COORD_W-1:0] m;
		m = a;
		if (b < m) m = b;
		if (c < m) m = c;
		return m;
	endfunction

	function automatic logic [COORD_W-1:0] max3(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] c);
		logic [COORD_W-1:0] m;
		m = a;
		if (b > m) m = b;
		if (c > m) m = c;
		return m;
	endfunction

	function automatic logic signed [OPND_W-1:0] sub_op(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		return $signed({2'b00, a}) - $signed({2'b00, b});
	endfunction

	function automatic logic signed [EDGE_W-1:0] step_of(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		d = $signed({1'b0, a}) - $signed({1'b0, b});
		return EDGE_W'(d);
	endfunction

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp_load  = (state_q == S_FINISH) && out_free;

	assign xmin = min3(cmd.ax, cmd.bx, cmd.cx);
	assign xmax = max3(cmd.ax, cmd.bx, cmd.cx);
	assign ymin = min3(cmd.ay, cmd.by, cmd.cy);
	assign ymax = max3(cmd.ay, cmd.by, cmd.cy);
	assign xlim = (xmax > COL_LAST) ? COL_LAST : xmax;
	assign ylim = (ymax > ROW_LAST) ? ROW_LAST : ymax;

	// per-pixel steps of each edge value: along x uy-vy, along y vx-ux
	assign dx_ext[0] = step_of(vy_q[0], vy_q[1]);
	assign dx_ext[1] = step_of(vy_q[1], vy_q[2]);
	assign dx_ext[2] = step_of(vy_q[2], vy_q[0]);
	assign dy_ext[0] = step_of(vx_q[1], vx_q[0]);
	assign dy_ext[1] = step_of(vx_q[2], vx_q[1]);
	assign dy_ext[2] = step_of(vx_q[0], vx_q[2]);

	// shared multiplier operands: edge products at box corner, then row base; for a read, the read row base
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_RADDR) begin
			mul_a = OPND_W'(rd_row_q);
			mul_b = OPND_W'(DISPLAY_COLUMNS);
		end else begin
			unique case (step_q)
				3'd0: begin
					mul_a = sub_op(vx_q[0], x0_q);
					mul_b = sub_op(vy_q[1], y0_q);
				end
				3'd1: begin
					mul_a = sub_op(vy_q[0], y0_q);
					mul_b = sub_op(vx_q[1], x0_q);
				end
				3'd2: begin
					mul_a = sub_op(vx_q[1], x0_q);
					mul_b = sub_op(vy_q[2], y0_q);
				end
				3'd3: begin
					mul_a = sub_op(vy_q[1], y0_q);
					mul_b = sub_op(vx_q[2], x0_q);
				end
				3'd4: begin
					mul_a = sub_op(vx_q[2], x0_q);
					mul_b = sub_op(vy_q[0], y0_q);
				end
				3'd5: begin
					mul_a = sub_op(vy_q[2], y0_q);
					mul_b = sub_op(vx_q[0], x0_q);
				end
				3'd6: begin
					mul_a = OPND_W'(y0_q);
					mul_b = OPND_W'(DISPLAY_COLUMNS);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	// edge on a zero value counts as inside
	assign neg = e_q[0][EDGE_W-1] | e_q[1][EDGE_W-1] | e_q[2][EDGE_W-1];
	assign pos = (!e_q[0][EDGE_W-1] && (e_q[0] != '0)) ||
		(!e_q[1][EDGE_W-1] && (e_q[1] != '0)) ||
		(!e_q[2][EDGE_W-1] && (e_q[2] != '0));
	assign paint    = !(neg && pos);
	assign last_col = (x_q == x1_q);
	assign last_pix = last_col && (y_q == y1_q);

	assign ram_re    = (state_q == S_RREQ);
	assign ram_raddr = prod_q[ADDR_W-1:0] + ADDR_W'(rd_col_q);

	tfr_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (STORE_DEPTH)
	) u_frame (
		.clk   (clk),
		.we    ((state_q == S_SCAN) && paint),
		.waddr (addr_q),
		.wdata (color_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						step_q  <= '0;
						count_q <= '0;
						state_q <= (cmd.kind == KIND_READ) ? S_RADDR : S_SETUP;
					end
				end
				S_SETUP: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						state_q <= empty_q ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (paint) begin
						count_q <= count_q + COUNT_W'(1);
					end
					if (last_pix) begin
						state_q <= S_FINISH;
					end
				end
				S_RADDR: begin
					state_q <= S_RREQ;
				end
				S_RREQ: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd_fire) begin
			vx_q[0]   <= cmd.ax;
			vx_q[1]   <= cmd.bx;
			vx_q[2]   <= cmd.cx;
			vy_q[0]   <= cmd.ay;
			vy_q[1]   <= cmd.by;
			vy_q[2]   <= cmd.cy;
			x0_q      <= xmin;
			x1_q      <= xlim;
			y0_q      <= ymin;
			y1_q      <= ylim;
			x_q       <= xmin;
			y_q       <= ymin;
			empty_q   <= (xmin > xlim) || (ymin > ylim);
			is_read_q <= (cmd.kind == KIND_READ);
			rd_ok_q   <= ({2'b00, cmd.read_column} < 9'(DISPLAY_COLUMNS)) &&
				({3'b000, cmd.read_row} < 9'(DISPLAY_ROWS));
			rd_col_q  <= cmd.read_column;
			rd_row_q  <= cmd.read_row;
			color_q   <= {cmd.fill_red, cmd.fill_green, cmd.fill_blue};
		end
		if (state_q == S_SETUP) begin
			case (step_q)
				3'd1: e_q[0] <= prod_q;
				3'd2: e_q[0] <= e_q[0] - prod_q;
				3'd3: e_q[1] <= prod_q;
				3'd4: e_q[1] <= e_q[1] - prod_q;
				3'd5: e_q[2] <= prod_q;
				3'd6: e_q[2] <= e_q[2] - prod_q;
				3'd7: begin
					row_addr_q <= prod_q[ADDR_W-1:0];
					addr_q     <= prod_q[ADDR_W-1:0] + ADDR_W'(x0_q);
					for (int i = 0; i < 3; i++) begin
						er_q[i] <= e_q[i];
					end
				end
				default: ;
			endcase
		end
		if (state_q == S_SCAN) begin
			if (last_col) begin
				x_q        <= x0_q;
				y_q        <= y_q + COORD_W'(1);
				row_addr_q <= row_addr_q + ROW_STEP;
				addr_q     <= row_addr_q + ROW_STEP + ADDR_W'(x0_q);
				for (int i = 0; i < 3; i++) begin
					er_q[i] <= er_q[i] + dy_ext[i];
					e_q[i]  <= er_q[i] + dy_ext[i];
				end
			end else begin
				x_q    <= x_q + COORD_W'(1);
				addr_q <= addr_q + ADDR_W'(1);
				for (int i = 0; i < 3; i++) begin
					e_q[i] <= e_q[i] + dx_ext[i];
				end
			end
		end
		if ((state_q == S_FINISH) && out_free) begin
			if (is_read_q && rd_ok_q) begin
				pixel_red_q   <= ram_rdata[COLOR_W-1 -: CHAN_W];
				pixel_green_q <= ram_rdata[CHAN_W +: CHAN_W];
				pixel_blue_q  <= ram_rdata[CHAN_W-1:0];
			end else begin
				pixel_red_q   <= '0;
				pixel_green_q <= '0;
				pixel_blue_q  <= '0;
			end
			painted_count_q <= is_read_q ? '0 : count_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.pixel_red     = pixel_red_q;
	assign rsp.pixel_green   = pixel_green_q;
	assign rsp.pixel_blue    = pixel_blue_q;
	assign rsp.painted_count = painted_count_q;

endmodule

// ===== dv/tfr_checker.sv =====
// rasterizer checker: shadow frame store, expected results and compare on the response channel
module tfr_checker import tfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tfr_cmd_if   cmd,
	tfr_rsp_if   rsp,
	output int   fails,
	output int   outstanding
);

	typedef struct packed {
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [COUNT_W-1:0] painted;
	} pixel_result_t;

	logic [COLOR_W-1:0] shadow_frame [STORE_DEPTH];
	pixel_result_t      results_owed [$];

	function automatic int cross_at(int px, int py, int ux, int uy, int vx, int vy);
		return (ux - px) * (vy - py) - (uy - py) * (vx - px);
	endfunction

	function automatic pixel_result_t draw_triangle(int ax, int ay, int bx, int by,
			int cx, int cy, logic [COLOR_W-1:0] rgb);
		pixel_result_t r;
		int xlo, xhi, ylo, yhi, e1, e2, e3, n;
		r = '0;
		n = 0;
		xlo = ax;
		if (bx < xlo) xlo = bx;
		if (cx < xlo) xlo = cx;
		xhi = ax;
		if (bx > xhi) xhi = bx;
		if (cx > xhi) xhi = cx;
		ylo = ay;
		if (by < ylo) ylo = by;
		if (cy < ylo) ylo = cy;
		yhi = ay;
		if (by > yhi) yhi = by;
		if (cy > yhi) yhi = cy;
		// clip the box to the display, off-screen pixels are never tested
		if (xhi > DISPLAY_COLUMNS - 1) xhi = DISPLAY_COLUMNS - 1;
		if (yhi > DISPLAY_ROWS - 1) yhi = DISPLAY_ROWS - 1;
		for (int x = xlo; x <= xhi; x++) begin
			for (int y = ylo; y <= yhi; y++) begin
				e1 = cross_at(x, y, ax, ay, bx, by);
				e2 = cross_at(x, y, bx, by, cx, cy);
				e3 = cross_at(x, y, cx, cy, ax, ay);
				// zero on any edge counts as inside
				if (!((e1 < 0 || e2 < 0 || e3 < 0) && (e1 > 0 || e2 > 0 || e3 > 0))) begin
					shadow_frame[y * DISPLAY_COLUMNS + x] = rgb;
					n++;
				end
			end
		end
		r.painted = COUNT_W'(n);
		return r;
	endfunction

	function automatic pixel_result_t read_pixel(int col, int row);
		pixel_result_t r;
		r = '0;
		if (col < DISPLAY_COLUMNS && row < DISPLAY_ROWS)
			{r.red, r.green, r.blue} = shadow_frame[row * DISPLAY_COLUMNS + col];
		return r;
	endfunction

	always @(posedge clk) begin
		pixel_result_t got, want;
		if (!arst_n) begin
			fails = 0;
			outstanding = 0;
			results_owed.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.red     = rsp.pixel_red;
				got.green   = rsp.pixel_green;
				got.blue    = rsp.pixel_blue;
				got.painted = rsp.painted_count;
				if (results_owed.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: red %h green %h blue %h count %0d",
							got.red, got.green, got.blue, got.painted);
				end else begin
					want = results_owed.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10)
							$display("result mismatch: expected %h %h %h count %0d, got %h %h %h count %0d",
								want.red, want.green, want.blue, want.painted,
								got.red, got.green, got.blue, got.painted);
					end
				end
			end
			// command transfer: predict now, the store update is in order
			if (cmd.valid && cmd.ready) begin
				if (cmd.kind == KIND_READ)
					results_owed.push_back(read_pixel(int'(cmd.read_column), int'(cmd.read_row)));
				else
					results_owed.push_back(draw_triangle(int'(cmd.ax), int'(cmd.ay),
						int'(cmd.bx), int'(cmd.by), int'(cmd.cx), int'(cmd.cy),
						{cmd.fill_red, cmd.fill_green, cmd.fill_blue}));
			end
			outstanding = results_owed.size();
		end
	end

endmodule

// ===== dv/tb_triangle_fill_rasterizer.sv =====
// testbench top for the triangle fill rasterizer: stimulus, response stalls and verdict
module tb_triangle_fill_rasterizer;
	import tfr_pkg::*;

	typedef struct packed {
		logic                kind;
		logic [COORD_W-1:0]  ax;
		logic [COORD_W-1:0]  ay;
		logic [COORD_W-1:0]  bx;
		logic [COORD_W-1:0]  by;
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cy;
		logic [COLOR_W-1:0]  rgb;
		logic [RD_COL_W-1:0] col;
		logic [RD_ROW_W-1:0] row;
	} command_t;

	localparam int IDLE_LIMIT  = 40000;
	localparam int HOLD_CYCLES = 3000;
	localparam int HOLD_AFTER  = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fails;
	int   outstanding;
	int   idle_cycles = 0;
	int   burst_left  = 0;

	tfr_cmd_if cmd ();
	tfr_rsp_if rsp ();

	triangle_fill_rasterizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	tfr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	function automatic command_t draw_cmd(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
			logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
			logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, logic [COLOR_W-1:0] rgb);
		command_t c;
		c.kind = KIND_DRAW;
		c.ax   = ax;
		c.ay   = ay;
		c.bx   = bx;
		c.by   = by;
		c.cx   = cx;
		c.cy   = cy;
		c.rgb  = rgb;
		c.col  = RD_COL_W'($urandom);
		c.row  = RD_ROW_W'($urandom);
		return c;
	endfunction

	function automatic command_t read_cmd(logic [RD_COL_W-1:0] col, logic [RD_ROW_W-1:0] row);
		command_t c;
		c.kind = KIND_READ;
		c.ax   = COORD_W'($urandom);
		c.ay   = COORD_W'($urandom);
		c.bx   = COORD_W'($urandom);
		c.by   = COORD_W'($urandom);
		c.cx   = COORD_W'($urandom);
		c.cy   = COORD_W'($urandom);
		c.rgb  = COLOR_W'($urandom);
		c.col  = col;
		c.row  = row;
		return c;
	endfunction

	// hold the command until its transfer, then maybe pause between bursts
	task automatic offer(command_t c);
		cmd.valid       <= 1'b1;
		cmd.kind        <= c.kind;
		cmd.ax          <= c.ax;
		cmd.ay          <= c.ay;
		cmd.bx          <= c.bx;
		cmd.by          <= c.by;
		cmd.cx          <= c.cx;
		cmd.cy          <= c.cy;
		cmd.fill_red    <= c.rgb[23:16];
		cmd.fill_green  <= c.rgb[15:8];
		cmd.fill_blue   <= c.rgb[7:0];
		cmd.read_column <= c.col;
		cmd.read_row    <= c.row;
		do @(posedge clk); while (!cmd.ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 10);
		end
	endtask

	initial begin
		int pick;
		logic [COORD_W-1:0] ox, oy;
		ox = '0;
		oy = '0;
		cmd.valid       <= 1'b0;
		cmd.kind        <= KIND_DRAW;
		cmd.ax          <= '0;
		cmd.ay          <= '0;
		cmd.bx          <= '0;
		cmd.by          <= '0;
		cmd.cx          <= '0;
		cmd.cy          <= '0;
		cmd.fill_red    <= '0;
		cmd.fill_green  <= '0;
		cmd.fill_blue   <= '0;
		cmd.read_column <= '0;
		cmd.read_row    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cover the whole display first so every on-screen read hits a written pixel
		offer(draw_cmd(0, 0, 255, 0, 0, 255, 24'hff00a5));
		offer(read_cmd(0, 0));
		offer(read_cmd(119, 47));
		offer(read_cmd(127, 63));
		offer(read_cmd(120, 5));
		offer(read_cmd(7, 48));
		// coincident vertices paint a single pixel
		offer(draw_cmd(5, 5, 5, 5, 5, 5, 24'h000000));
		offer(read_cmd(5, 5));
		// collinear vertices: only the segment itself
		offer(draw_cmd(10, 10, 20, 10, 15, 10, 24'h123456));
		offer(draw_cmd(0, 0, 40, 40, 20, 20, 24'hffffff));
		// fully off the display
		offer(draw_cmd(200, 100, 250, 100, 220, 200, 24'h654321));
		offer(draw_cmd(255, 255, 255, 255, 255, 255, 24'habcdef));
		// partly off the display
		offer(draw_cmd(100, 40, 255, 40, 100, 255, 24'h5a5a5a));
		offer(read_cmd(110, 45));
		// both windings of the same triangle
		offer(draw_cmd(30, 5, 50, 25, 30, 25, 24'ha5c3e1));
		offer(draw_cmd(30, 5, 30, 25, 50, 25, 24'h3c1e0f));
		offer(read_cmd(35, 20));
		offer(draw_cmd(0, 0, 0, 255, 255, 0, 24'h000000));
		offer(read_cmd(60, 30));
		offer(draw_cmd(119, 47, 119, 0, 0, 47, 24'hffffff));
		offer(read_cmd(119, 47));

		for (int i = 0; i < 100; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				offer(draw_cmd(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
					COLOR_W'($urandom)));
			end else if (pick < 45) begin
				// small triangle near the display, read back around it afterwards
				ox = COORD_W'($urandom_range(0, 125));
				oy = COORD_W'($urandom_range(0, 52));
				offer(draw_cmd(ox + COORD_W'($urandom_range(0, 14)),
					oy + COORD_W'($urandom_range(0, 14)),
					ox + COORD_W'($urandom_range(0, 14)),
					oy + COORD_W'($urandom_range(0, 14)),
					ox + COORD_W'($urandom_range(0, 14)),
					oy + COORD_W'($urandom_range(0, 14)),
					COLOR_W'($urandom)));
			end else if (pick < 85) begin
				offer(read_cmd(RD_COL_W'(ox + COORD_W'($urandom_range(0, 14))),
					RD_ROW_W'(oy + COORD_W'($urandom_range(0, 14)))));
			end else begin
				offer(read_cmd(RD_COL_W'($urandom), RD_ROW_W'($urandom)));
			end
		end

		cmd.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (16) @(posedge clk);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// response side: random open and closed runs, one long hold to back up the block
	initial begin
		int  taken, run_left, stall_left;
		logic open_phase;
		bit  held;
		taken      = 0;
		run_left   = 0;
		stall_left = 0;
		open_phase = 1'b0;
		held       = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) taken++;
			if (!held && taken >= HOLD_AFTER) begin
				held       = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (run_left == 0) begin
				open_phase = !open_phase;
				if (!open_phase)
					run_left = $urandom_range(1, 5);
				else if ($urandom_range(0, 3) == 0)
					run_left = 64;
				else
					run_left = $urandom_range(1, 12);
			end
			run_left--;
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= open_phase;
			end
		end
	end

	// watchdog: cycles without any transfer on either channel
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
